// ===== design/qpid_pkg.sv =====
// ----------------------------------------------------------------------------
// qpid_pkg: shared types and constants of the Q15 PID controller
// Register indexes, sequencer states, limits and the Q15 saturation helper.
// ----------------------------------------------------------------------------
package qpid_pkg;

    localparam int unsigned DataW = 16;
    localparam int unsigned CfgAddrW = 3;
    localparam int unsigned ProdW = 34;
    localparam int unsigned SumW = 18;
    localparam int unsigned DivSteps = 16;
    localparam int unsigned DivCntW = 4;

    // Accepted sample period range in ms, both ends inclusive.
    localparam logic [DataW-1:0] TS_MIN = 16'd51;
    localparam logic [DataW-1:0] TS_MAX = 16'd19999;

    localparam logic [CfgAddrW-1:0] REG_PROP_GAIN = 3'd0;
    localparam logic [CfgAddrW-1:0] REG_DERIV_GAIN = 3'd1;
    localparam logic [CfgAddrW-1:0] REG_INT_TIME = 3'd2;
    localparam logic [CfgAddrW-1:0] REG_INT_LIMIT = 3'd3;
    localparam logic [CfgAddrW-1:0] REG_SAMPLE_PERIOD = 3'd4;
    localparam logic [CfgAddrW-1:0] REG_OUTPUT_MAX = 3'd5;

    localparam logic [DataW-1:0] SAMPLE_PERIOD_RST = 16'd100;
    localparam logic [14:0] OUTPUT_MAX_RST = 15'h7FFF;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_MUL_I,
        S_ACC,
        S_MUL_P,
        S_MUL_D,
        S_SUM,
        S_DONE
    } state_t;

    // Floor shift by 15 of a signed product, saturated to 16 bits.
    function automatic logic signed [DataW-1:0] q15_sat(input logic signed [ProdW-1:0] p);
        logic signed [ProdW-16:0] q;
        begin
            q = p[ProdW-1:15];
            if (q > $signed(19'sd32767)) begin
                q15_sat = 16'sh7FFF;
            end
            else if (q < $signed(-19'sd32768)) begin
                q15_sat = 16'sh8000;
            end
            else begin
                q15_sat = q[DataW-1:0];
            end
        end
    endfunction

endpackage

// ===== design/q15_pid_with_integral_clamp.sv =====
// ----------------------------------------------------------------------------
// q15_pid_with_integral_clamp: discrete PID step with Q15 gains
// One item runs one control step or clears the controller state.
// ----------------------------------------------------------------------------
// Each item is accepted in S_IDLE and checked in S_CHECK, then runs a serial
// restoring division in S_DIV when the integral is enabled and its time
// constant differs from the cached one, then the multiply and add states
// S_MUL_I, S_ACC, S_MUL_P, S_MUL_D, S_SUM on one shared 17x17 multiplier
// (only S_MUL_P, S_MUL_D, S_SUM when the integral is disabled), then S_DONE
// hands the result to the output register; a clear or a parameter error goes
// from S_CHECK to S_DONE. The block takes no new item until the current one
// has reached the output register, so a stalled output adds its stall cycles
// to the next item; a waiting result does not block acceptance of the next.
// Configuration writes are taken in any cycle and must only be issued while
// the block is idle.
module q15_pid_with_integral_clamp (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [15:0] setpoint, [31:16] measured
    input  logic        s_axis_tuser,   // [0] func: 0 run a step, 1 clear state
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] drive
    output logic        m_axis_tuser,   // [0] param_error
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [qpid_pkg::CfgAddrW-1:0] cfg_addr,
    input  logic [qpid_pkg::DataW-1:0]    cfg_data
);
    import qpid_pkg::*;

    state_t state_reg, state_next;

    logic signed [DataW-1:0] prop_gain_reg, deriv_gain_reg;
    logic [DataW-1:0] int_time_reg, sample_period_reg;
    logic [14:0] int_limit_reg, output_max_reg;

    logic [31:0] integral_acc_reg;
    logic signed [DataW-1:0] last_error_reg;
    logic [DataW-1:0] integral_gain_reg, cached_time_reg;

    logic func_reg;
    logic signed [DataW-1:0] err_reg;
    logic signed [ProdW-1:0] prod_reg;
    logic signed [SumW-1:0] sum_reg;
    logic [DataW-1:0] rem_reg, quo_reg;
    logic [DivCntW-1:0] cnt_reg;
    logic signed [DataW-1:0] res_drive_reg;
    logic res_perr_reg;

    logic out_valid_reg;
    logic [DataW-1:0] out_drive_reg;
    logic out_perr_reg;

    logic params_ok, int_enabled, gain_stale, out_free;
    logic signed [DataW:0] mul_a, mul_b;
    logic signed [DataW-1:0] diff;
    logic [DataW:0] div_shift;
    logic div_bit;
    logic [31:0] acc_sum;
    logic signed [DataW-1:0] acc_hi, lim_s, hi_clamped;
    logic signed [SumW-1:0] total, om_s;
    logic signed [DataW-1:0] total_clamped;

    assign params_ok = (sample_period_reg >= TS_MIN) && (sample_period_reg <= TS_MAX)
                       && (output_max_reg != 15'd0);
    assign int_enabled = {1'b0, int_time_reg} > {sample_period_reg, 1'b0};
    assign gain_stale = int_time_reg != cached_time_reg;
    assign out_free = !out_valid_reg || m_axis_tready;

    // Restoring division step; the remainder always stays below the divisor.
    assign div_shift = {rem_reg, 1'b0};
    assign div_bit = div_shift >= {1'b0, int_time_reg};

    assign diff = err_reg - last_error_reg;

    // Integral update: wrap the 32-bit sum, then clamp its upper half.
    assign acc_sum = integral_acc_reg + prod_reg[31:0];
    assign acc_hi = acc_sum[31:16];
    assign lim_s = $signed({1'b0, int_limit_reg});
    always_comb
    begin
        if (acc_hi > lim_s) begin
            hi_clamped = lim_s;
        end
        else if (acc_hi < -lim_s) begin
            hi_clamped = -lim_s;
        end
        else begin
            hi_clamped = acc_hi;
        end
    end

    assign total = sum_reg + SumW'(q15_sat(prod_reg));
    assign om_s = $signed({3'b000, output_max_reg});
    always_comb
    begin
        if (total > om_s) begin
            total_clamped = om_s[DataW-1:0];
        end
        else if (total < -om_s) begin
            total_clamped = -om_s[DataW-1:0];
        end
        else begin
            total_clamped = total[DataW-1:0];
        end
    end

    // Operand selection for the shared multiplier.
    always_comb
    begin
        case (state_reg)
            S_MUL_I:
            begin
                mul_a = $signed({1'b0, integral_gain_reg});
                mul_b = {err_reg[DataW-1], err_reg};
            end
            S_MUL_D:
            begin
                mul_a = {deriv_gain_reg[DataW-1], deriv_gain_reg};
                mul_b = {diff[DataW-1], diff};
            end
            default:
            begin
                mul_a = {prop_gain_reg[DataW-1], prop_gain_reg};
                mul_b = {err_reg[DataW-1], err_reg};
            end
        endcase
    end

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid) begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (func_reg || !params_ok) begin
                    state_next = S_DONE;
                end
                else if (!int_enabled) begin
                    state_next = S_MUL_P;
                end
                else if (gain_stale) begin
                    state_next = S_DIV;
                end
                else begin
                    state_next = S_MUL_I;
                end
            end
            S_DIV:
            begin
                if (cnt_reg == DivCntW'(DivSteps - 1)) begin
                    state_next = S_MUL_I;
                end
            end
            S_MUL_I: state_next = S_ACC;
            S_ACC: state_next = S_MUL_P;
            S_MUL_P: state_next = S_MUL_D;
            S_MUL_D: state_next = S_SUM;
            S_SUM: state_next = S_DONE;
            S_DONE:
            begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Handshake outputs.
    always_comb
    begin
        s_axis_tready = state_reg == S_IDLE;
        cfg_ready = 1'b1;
        m_axis_tvalid = out_valid_reg;
        m_axis_tdata = out_drive_reg;
        m_axis_tuser = out_perr_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= S_IDLE;
        end
        else begin
            state_reg <= state_next;
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            prop_gain_reg <= '0;
            deriv_gain_reg <= '0;
            int_time_reg <= '0;
            int_limit_reg <= '0;
            sample_period_reg <= SAMPLE_PERIOD_RST;
            output_max_reg <= OUTPUT_MAX_RST;
        end
        else if (cfg_valid) begin
            case (cfg_addr)
                REG_PROP_GAIN: prop_gain_reg <= cfg_data;
                REG_DERIV_GAIN: deriv_gain_reg <= cfg_data;
                REG_INT_TIME: int_time_reg <= cfg_data;
                REG_INT_LIMIT: int_limit_reg <= cfg_data[14:0];
                REG_SAMPLE_PERIOD: sample_period_reg <= cfg_data;
                REG_OUTPUT_MAX: output_max_reg <= cfg_data[14:0];
                default: ;
            endcase
        end
    end

    // Controller state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            integral_acc_reg <= '0;
            last_error_reg <= '0;
            integral_gain_reg <= '0;
            cached_time_reg <= '0;
        end
        else begin
            case (state_reg)
                S_CHECK:
                begin
                    if (func_reg) begin
                        integral_acc_reg <= '0;
                        last_error_reg <= '0;
                    end
                    else if (params_ok && !int_enabled) begin
                        integral_acc_reg <= '0;
                    end
                end
                S_DIV:
                begin
                    if (cnt_reg == DivCntW'(DivSteps - 1)) begin
                        integral_gain_reg <= {quo_reg[DataW-2:0], div_bit};
                        cached_time_reg <= int_time_reg;
                    end
                end
                S_ACC: integral_acc_reg <= {hi_clamped, acc_sum[15:0]};
                S_SUM: last_error_reg <= err_reg;
                default: ;
            endcase
        end
    end

    // Working registers of one item.
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        case (state_reg)
            S_IDLE:
            begin
                func_reg <= s_axis_tuser;
                err_reg <= s_axis_tdata[15:0] - s_axis_tdata[31:16];
            end
            S_CHECK:
            begin
                rem_reg <= sample_period_reg;
                cnt_reg <= '0;
                res_drive_reg <= '0;
                res_perr_reg <= !func_reg && !params_ok;
            end
            S_DIV:
            begin
                rem_reg <= div_bit ? DataW'(div_shift - {1'b0, int_time_reg})
                                   : div_shift[DataW-1:0];
                quo_reg <= {quo_reg[DataW-2:0], div_bit};
                cnt_reg <= cnt_reg + 1'b1;
            end
            S_MUL_D: sum_reg <= SumW'(q15_sat(prod_reg)) + SumW'($signed(integral_acc_reg[31:16]));
            S_SUM:
            begin
                res_drive_reg <= total_clamped;
                res_perr_reg <= 1'b0;
            end
            default: ;
        endcase
    end

    // Output register: loaded when the finished item finds it free.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end
        else if (state_reg == S_DONE && out_free) begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_DONE && out_free) begin
            out_drive_reg <= res_drive_reg;
            out_perr_reg <= res_perr_reg;
        end
    end

endmodule

// ===== test/tb_q15_pid_with_integral_clamp.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_q15_pid_with_integral_clamp: self-checking bench of the Q15 PID step
// Short directed tests cover the field extremes, the clear command, invalid
// parameters, integral clamping and a stale integral gain. Random traffic
// then runs in four idling phases with random register settings. An
// in-bench predictor computes every result, and a checker compares it.
// ----------------------------------------------------------------------------
module tb_q15_pid_with_integral_clamp;
    import qpid_pkg::*;

    localparam logic FUNC_STEP = 1'b0;
    localparam logic FUNC_CLEAR = 1'b1;
    localparam int WatchdogLimit = 3000;
    localparam int DrainCycles = 30;
    localparam int ReconfigEvery = 40;

    typedef enum int {
        PH_NONE,
        PH_SRC,
        PH_SINK,
        PH_BOTH
    } idle_phase_t;

    typedef struct packed {
        logic signed [15:0] drive;
        logic               param_error;
    } pid_result_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [31:0]         s_axis_tdata = '0;    // [15:0] setpoint, [31:16] measured
    logic                s_axis_tuser = 1'b0;  // [0] func
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [15:0]         m_axis_tdata;         // [15:0] drive
    logic                m_axis_tuser;         // [0] param_error
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [CfgAddrW-1:0] cfg_addr = '0;
    logic [DataW-1:0]    cfg_data = '0;

    // Predictor copy of the registers and the controller state.
    logic signed [15:0] kp;
    logic signed [15:0] kd;
    logic [15:0]        ti_ms;
    logic [15:0]        ts_ms;
    logic [14:0]        i_lim;
    logic [14:0]        out_max;
    logic [31:0]        i_acc;
    logic signed [15:0] prev_err;
    logic [15:0]        ki;
    logic [15:0]        ki_ti;

    pid_result_t drive_expect_q[$];
    int          error_count = 0;
    int          quiet_cycles = 0;
    int          src_idle_pct = 0;
    int          sink_stall_pct = 0;

    q15_pid_with_integral_clamp u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_addr      (cfg_addr),
        .cfg_data      (cfg_data)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WatchdogLimit)
        begin
            $display("tb_q15_pid_with_integral_clamp: done, errors");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    always @(posedge clk)
    begin
        pid_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (drive_expect_q.size() == 0)
            begin
                $error("unexpected result: drive %0d, param_error %0b",
                       $signed(m_axis_tdata), m_axis_tuser);
                error_count++;
            end
            else
            begin
                want = drive_expect_q.pop_front();
                if (m_axis_tdata !== want.drive)
                begin
                    $error("drive: expected %0d, got %0d", want.drive, $signed(m_axis_tdata));
                    error_count++;
                end
                if (m_axis_tuser !== want.param_error)
                begin
                    $error("param_error: expected %0b, got %0b", want.param_error,
                           m_axis_tuser);
                    error_count++;
                end
            end
        end
    end

    task automatic model_reset();
        kp = '0;
        kd = '0;
        ti_ms = '0;
        i_lim = '0;
        ts_ms = SAMPLE_PERIOD_RST;
        out_max = OUTPUT_MAX_RST;
        i_acc = '0;
        prev_err = '0;
        ki = '0;
        ki_ti = '0;
    endtask

    task automatic apply_reg(input logic [CfgAddrW-1:0] idx, input logic [15:0] value);
        case (idx)
            REG_PROP_GAIN:     kp = value;
            REG_DERIV_GAIN:    kd = value;
            REG_INT_TIME:      ti_ms = value;
            REG_INT_LIMIT:     i_lim = value[14:0];
            REG_SAMPLE_PERIOD: ts_ms = value;
            REG_OUTPUT_MAX:    out_max = value[14:0];
            default:           ;
        endcase
    endtask

    // Floor of (a*b)/2^15, saturated to the 16-bit range.
    function automatic int q15_product(input logic signed [15:0] a,
                                       input logic signed [15:0] b);
        int p;
        int r;
        p = int'(a) * int'(b);
        r = p >>> 15;
        if (r > 32767)
            r = 32767;
        if (r < -32768)
            r = -32768;
        return r;
    endfunction

    function automatic pid_result_t pid_step(input logic func,
                                             input logic signed [15:0] sp,
                                             input logic signed [15:0] fb);
        pid_result_t        res;
        logic signed [15:0] err;
        logic signed [15:0] derr;
        logic signed [15:0] hi;
        longint             gain;
        int                 h;
        int                 sum;
        int                 lim;
        res = '0;
        if (func == FUNC_CLEAR)
        begin
            i_acc = '0;
            prev_err = '0;
        end
        else if (ts_ms >= TS_MIN && ts_ms <= TS_MAX && out_max != '0)
        begin
            err = sp - fb;
            if (int'(ti_ms) > 2 * int'(ts_ms))
            begin
                // The gain is cached on the integral time alone.
                if (ti_ms != ki_ti)
                begin
                    gain = (longint'(ts_ms) * 65536) / longint'(ti_ms);
                    ki = gain[15:0];
                    ki_ti = ti_ms;
                end
                i_acc = i_acc + 32'(int'(ki) * int'(err));
                h = int'($signed(i_acc[31:16]));
                if (h > int'(i_lim))
                    h = int'(i_lim);
                if (h < -int'(i_lim))
                    h = -int'(i_lim);
                i_acc[31:16] = h[15:0];
            end
            else
            begin
                i_acc = '0;
            end
            hi = $signed(i_acc[31:16]);
            derr = err - prev_err;
            sum = q15_product(kp, err) + int'(hi) + q15_product(kd, derr);
            lim = int'(out_max);
            if (sum > lim)
                sum = lim;
            if (sum < -lim)
                sum = -lim;
            res.drive = sum[15:0];
            prev_err = err;
        end
        else
        begin
            res.param_error = 1'b1;
        end
        return res;
    endfunction

    // Valid is left high after an item unless an idle gap follows, so that
    // back-to-back items never lower and raise it in one step.
    task automatic send_item(input logic func, input logic signed [15:0] sp,
                             input logic signed [15:0] fb);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= func;
        s_axis_tdata <= {fb, sp};
        do
            @(posedge clk);
        while (!s_axis_tready);
        drive_expect_q.push_back(pid_step(func, sp, fb));
        if ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < src_idle_pct)
                @(posedge clk);
        end
    endtask

    task automatic wait_quiescent();
        s_axis_tvalid <= 1'b0;
        while (drive_expect_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CfgAddrW-1:0] idx, input logic [15:0] value);
        wait_quiescent();
        cfg_valid <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        apply_reg(idx, value);
        @(posedge clk);
    endtask

    function automatic logic [15:0] pick_gain();
        case ($urandom_range(5))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h0000;
            3:       return 16'($urandom_range(2047));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic randomize_config();
        logic [15:0] ts;
        logic [15:0] ti;
        int          span;
        case ($urandom_range(19))
            0:       ts = 16'd50;
            1:       ts = 16'd20000;
            2:       ts = 16'($urandom);
            3:       ts = TS_MIN;
            4:       ts = TS_MAX;
            default: ts = 16'($urandom_range(2000, 51));
        endcase
        span = 2 * int'(ts) + 1 + $urandom_range(4000);
        case ($urandom_range(7))
            0:       ti = ts << 1;
            1:       ti = 16'($urandom);
            default: ti = (span > 65535) ? 16'hFFFF : span[15:0];
        endcase
        write_reg(REG_PROP_GAIN, pick_gain());
        write_reg(REG_DERIV_GAIN, pick_gain());
        write_reg(REG_SAMPLE_PERIOD, ts);
        // Leaving the integral time alone now and then keeps a stale gain.
        if ($urandom_range(3) != 0)
            write_reg(REG_INT_TIME, ti);
        case ($urandom_range(5))
            0:       write_reg(REG_INT_LIMIT, 16'h0000);
            1:       write_reg(REG_INT_LIMIT, 16'h7FFF);
            2:       write_reg(REG_INT_LIMIT, 16'($urandom_range(64)));
            default: write_reg(REG_INT_LIMIT, 16'($urandom_range(32767)));
        endcase
        case ($urandom_range(15))
            0:       write_reg(REG_OUTPUT_MAX, 16'h0000);
            1:       write_reg(REG_OUTPUT_MAX, 16'h7FFF);
            2:       write_reg(REG_OUTPUT_MAX, 16'h0001);
            default: write_reg(REG_OUTPUT_MAX, 16'($urandom_range(32767, 1)));
        endcase
    endtask

    task automatic test_reset_values();
        send_item(FUNC_STEP, 16'sd1000, -16'sd1000);
        send_item(FUNC_STEP, 16'sh7FFF, 16'sh8000);
    endtask

    task automatic test_gain_extremes();
        write_reg(REG_PROP_GAIN, 16'h7FFF);
        write_reg(REG_DERIV_GAIN, 16'h8000);
        write_reg(REG_INT_LIMIT, 16'h7FFF);
        write_reg(REG_SAMPLE_PERIOD, TS_MAX);
        write_reg(REG_INT_TIME, 16'hFFFF);
        write_reg(REG_OUTPUT_MAX, 16'h7FFF);
        send_item(FUNC_CLEAR, 16'sh7FFF, 16'sh7FFF);
        send_item(FUNC_STEP, 16'sh8000, 16'sh0000);
        send_item(FUNC_STEP, 16'sh7FFF, 16'sh8000);
        send_item(FUNC_STEP, 16'sh8000, 16'sh7FFF);
        send_item(FUNC_STEP, 16'sh7FFF, 16'sh0000);
        send_item(FUNC_STEP, 16'sh0000, 16'sh0000);
    endtask

    task automatic test_param_checks();
        write_reg(REG_SAMPLE_PERIOD, 16'd50);
        send_item(FUNC_STEP, 16'sd300, 16'sd100);
        send_item(FUNC_CLEAR, 16'sd300, 16'sd100);
        write_reg(REG_SAMPLE_PERIOD, TS_MIN);
        send_item(FUNC_STEP, 16'sd300, 16'sd100);
        write_reg(REG_SAMPLE_PERIOD, 16'd20000);
        send_item(FUNC_STEP, 16'sd300, 16'sd100);
        write_reg(REG_SAMPLE_PERIOD, 16'd0);
        send_item(FUNC_STEP, -16'sd300, 16'sd100);
        write_reg(REG_SAMPLE_PERIOD, 16'hFFFF);
        send_item(FUNC_STEP, -16'sd300, 16'sd100);
        write_reg(REG_SAMPLE_PERIOD, TS_MAX);
        write_reg(REG_OUTPUT_MAX, 16'h0000);
        send_item(FUNC_STEP, 16'sd300, 16'sd100);
        write_reg(REG_OUTPUT_MAX, 16'h0001);
        send_item(FUNC_STEP, 16'sd300, 16'sd100);
    endtask

    task automatic test_integral_clamp();
        write_reg(REG_OUTPUT_MAX, 16'h7FFF);
        write_reg(REG_PROP_GAIN, 16'h0000);
        write_reg(REG_DERIV_GAIN, 16'h0000);
        write_reg(REG_SAMPLE_PERIOD, 16'd100);
        write_reg(REG_INT_TIME, 16'd201);
        write_reg(REG_INT_LIMIT, 16'd3);
        send_item(FUNC_STEP, 16'sd20000, 16'sd0);
        send_item(FUNC_STEP, 16'sd20000, 16'sd0);
        send_item(FUNC_STEP, -16'sd20000, 16'sd0);
        send_item(FUNC_STEP, -16'sd20000, 16'sd0);
        write_reg(REG_INT_LIMIT, 16'd0);
        send_item(FUNC_STEP, 16'sd20000, 16'sd0);
        // Exactly twice the sample period disables and zeroes the integral.
        write_reg(REG_INT_LIMIT, 16'h7FFF);
        write_reg(REG_INT_TIME, 16'd200);
        send_item(FUNC_STEP, 16'sd20000, 16'sd0);
    endtask

    task automatic test_stale_gain();
        write_reg(REG_INT_TIME, 16'd201);
        write_reg(REG_SAMPLE_PERIOD, TS_MIN);
        send_item(FUNC_STEP, 16'sd12000, -16'sd500);
        send_item(FUNC_STEP, 16'sd12000, -16'sd500);
        write_reg(REG_INT_TIME, 16'd500);
        send_item(FUNC_STEP, 16'sd12000, -16'sd500);
    endtask

    task automatic test_random_traffic(input idle_phase_t phase, input int n_items);
        logic               func;
        logic signed [15:0] sp;
        logic signed [15:0] fb;
        wait_quiescent();
        case (phase)
            PH_SRC:
            begin
                src_idle_pct = 75;
                sink_stall_pct = 0;
            end
            PH_SINK:
            begin
                src_idle_pct = 0;
                sink_stall_pct = 75;
            end
            PH_BOTH:
            begin
                src_idle_pct = 35;
                sink_stall_pct = 35;
            end
            default:
            begin
                src_idle_pct = 0;
                sink_stall_pct = 0;
            end
        endcase
        for (int i = 0; i < n_items; i++)
        begin
            if (i % ReconfigEvery == 0)
                randomize_config();
            func = ($urandom_range(24) == 0) ? FUNC_CLEAR : FUNC_STEP;
            sp = 16'($urandom);
            // Half the items keep the error small so the integral can settle.
            if ($urandom_range(1) == 0)
                fb = 16'($urandom);
            else
                fb = sp + 16'($urandom_range(512)) - 16'sd256;
            send_item(func, sp, fb);
        end
    endtask

    initial
    begin
        model_reset();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_values();
        test_gain_extremes();
        test_param_checks();
        test_integral_clamp();
        test_stale_gain();
        test_random_traffic(PH_NONE, 240);
        test_random_traffic(PH_SRC, 240);
        test_random_traffic(PH_SINK, 240);
        test_random_traffic(PH_BOTH, 240);
        wait_quiescent();
        repeat (DrainCycles) @(posedge clk);
        if (drive_expect_q.size() != 0)
        begin
            $error("%0d results never arrived", drive_expect_q.size());
            error_count++;
        end
        if (error_count == 0)
            $display("tb_q15_pid_with_integral_clamp: done, clean");
        else
            $display("tb_q15_pid_with_integral_clamp: done, errors");
        $finish;
    end

endmodule

// ===== q15_pid_with_integral_clamp.f =====
design/qpid_pkg.sv
design/q15_pid_with_integral_clamp.sv
test/tb_q15_pid_with_integral_clamp.sv
